FILE: rtl/rhp_pkg.sv
package rhp_pkg;

	// Default build sizes
	localparam int MAX_PACKET_BYTES_DEF = 1500;
	localparam int LENGTH_BITS_DEF      = 24;

	// Field widths fixed by the channel definitions
	localparam int NAL_LEN_W    = 24;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_MTU_W    = 11;

	// Packet layout
	localparam int MIN_PACKET   = 64;
	localparam int HDR_BYTES    = 12;
	localparam int FU_OVERHEAD  = 14;
	localparam int IDX_FU_IND   = 12;
	localparam int IDX_FU_HDR   = 13;
	localparam int IDX_FU_DATA  = 14;
	localparam int IDX_W        = 4;

	localparam logic [7:0] RTP_V2_BYTE = 8'h80;
	localparam logic [4:0] FU_A_TYPE   = 5'd28;
	localparam logic [6:0] PT_RESET    = 7'd96;
	localparam logic [10:0] MTU_RESET  = 11'd1500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SSRC       = 2'd0,
		CFG_PT         = 2'd1,
		CFG_MAX_PACKET = 2'd2,
		CFG_TS_STEP    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0]          ssrc;
		logic [6:0]           rtp_pt;
		logic [CFG_MTU_W-1:0] max_packet;
		logic [31:0]          timestamp_step;
	} cfg_t;

	// One packet-byte job: optional header prefix, then one NAL byte
	typedef struct packed {
		logic        hdr;
		logic        fu;
		logic        marker;
		logic [6:0]  pt;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [31:0] ssrc;
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
		logic [7:0]  data;
		logic        last;
	} job_t;

endpackage

FILE: rtl/rhp_if.sv
interface rhp_nal_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [23:0] nal_length;
	logic        end_marker;

	modport source (output valid, kind, data_byte, nal_length, end_marker, input ready);
	modport sink (input valid, kind, data_byte, nal_length, end_marker, output ready);
endinterface

interface rhp_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       packet_last;

	modport source (output valid, packet_byte, packet_last, input ready);
	modport sink (input valid, packet_byte, packet_last, output ready);
endinterface

FILE: rtl/rhp_plan.sv
module rhp_plan #(
	parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF,
	parameter int LENGTH_BITS      = rhp_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rhp_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic          kind,
	input  logic [7:0]    data_byte,
	input  logic [23:0]   nal_length,
	input  logic          end_marker,
	output logic          job_valid,
	output rhp_pkg::job_t job
);
	import rhp_pkg::*;

	localparam int MTU_BITS = $clog2(MAX_PACKET_BYTES + 1);
	localparam int MW = (MTU_BITS > CFG_MTU_W) ? MTU_BITS : CFG_MTU_W;
	localparam int LW = (LENGTH_BITS < NAL_LEN_W) ? LENGTH_BITS : NAL_LEN_W;
	localparam int CW = ((LW > MW) ? LW : MW) + 1;

	logic [15:0]   seq_q;
	logic [31:0]   ts_q;
	logic [LW-1:0] rem_q;
	logic [MW-1:0] fill_q;
	logic          frag_q;
	logic [7:0]    fu_ind_q;
	logic [4:0]    utype_q;
	logic          first_q;
	logic          marker_q;

	logic [MW-1:0] mp;
	logic [MW-1:0] mtu;
	logic [MW-1:0] maxc;
	logic [LW-1:0] n_raw;
	logic [LW-1:0] n_eff;
	logic [LW-1:0] rem_first;
	logic [LW-1:0] rem_dec;
	logic [MW-1:0] fill_inc;
	logic          fits;
	logic          end_frag;
	logic          frag_last;

	// Clamp the packet limit and derive the fragment payload size
	assign mp   = MW'(cfg.max_packet);
	assign mtu  = (mp < MW'(MIN_PACKET)) ? MW'(MIN_PACKET) :
		(mp > MW'(MAX_PACKET_BYTES)) ? MW'(MAX_PACKET_BYTES) : mp;
	assign maxc = mtu - MW'(FU_OVERHEAD);

	// Length of a starting NAL; zero counts as one
	assign n_raw     = nal_length[LW-1:0];
	assign n_eff     = (n_raw == '0) ? LW'(1) : n_raw;
	assign rem_first = n_eff - LW'(1);
	assign fits      = (CW'(n_eff) + CW'(HDR_BYTES)) <= CW'(mtu);

	assign rem_dec   = rem_q - LW'(1);
	assign fill_inc  = fill_q + MW'(1);
	assign end_frag  = CW'(rem_q) <= CW'(maxc);
	assign frag_last = (rem_dec == '0) || (fill_inc >= maxc);

	// Decide the job for this transaction
	always_comb begin
		job_valid  = 1'b0;
		job.hdr    = 1'b0;
		job.fu     = 1'b0;
		job.marker = 1'b0;
		job.pt     = cfg.rtp_pt;
		job.seq    = seq_q;
		job.ts     = ts_q;
		job.ssrc   = cfg.ssrc;
		job.fu_ind = fu_ind_q;
		job.fu_hdr = {first_q, end_frag, 1'b0, utype_q};
		job.data   = data_byte;
		job.last   = 1'b0;
		if (!kind) begin
			if (rem_q == '0) begin
				if (fits) begin
					job_valid  = 1'b1;
					job.hdr    = 1'b1;
					job.marker = end_marker;
					job.last   = (rem_first == '0);
				end
			end else if (!frag_q) begin
				job_valid = 1'b1;
				job.last  = (rem_dec == '0);
			end else begin
				job_valid  = 1'b1;
				job.hdr    = (fill_q == '0);
				job.fu     = (fill_q == '0);
				job.marker = marker_q && end_frag;
				job.last   = frag_last;
			end
		end
	end

	// Advance stream state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			ts_q     <= '0;
			rem_q    <= '0;
			fill_q   <= '0;
			frag_q   <= 1'b0;
			fu_ind_q <= '0;
			utype_q  <= '0;
			first_q  <= 1'b0;
			marker_q <= 1'b0;
		end else if (accept) begin
			if (job_valid && job.hdr) begin
				seq_q <= seq_q + 16'd1;
			end
			if (kind) begin
				ts_q <= ts_q + cfg.timestamp_step;
			end else if (rem_q == '0) begin
				marker_q <= end_marker;
				rem_q    <= rem_first;
				if (fits) begin
					frag_q <= 1'b0;
				end else begin
					frag_q   <= 1'b1;
					fu_ind_q <= {data_byte[7:5], FU_A_TYPE};
					utype_q  <= data_byte[4:0];
					first_q  <= 1'b1;
					fill_q   <= '0;
				end
			end else if (!frag_q) begin
				rem_q <= rem_dec;
			end else begin
				if (fill_q == '0) begin
					first_q <= 1'b0;
				end
				rem_q  <= rem_dec;
				fill_q <= frag_last ? '0 : fill_inc;
			end
		end
	end

endmodule

FILE: rtl/rhp_emit.sv
module rhp_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          job_valid,
	input  rhp_pkg::job_t job,
	output logic          take_ready,
	rhp_pkt_if.source     pkt
);
	import rhp_pkg::*;

	logic             job_valid_s1;
	job_t             job_s1;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic       load;
	logic       at_data;
	logic [7:0] cur_byte;

	// Current byte of the held job
	always_comb begin
		if (!job_s1.hdr) begin
			at_data = 1'b1;
		end else if (job_s1.fu) begin
			at_data = (idx_q == IDX_W'(IDX_FU_DATA));
		end else begin
			at_data = (idx_q == IDX_W'(HDR_BYTES));
		end
	end

	always_comb begin
		if (at_data) begin
			cur_byte = job_s1.data;
		end else begin
			case (idx_q)
				4'd0:    cur_byte = RTP_V2_BYTE;
				4'd1:    cur_byte = {job_s1.marker, job_s1.pt};
				4'd2:    cur_byte = job_s1.seq[15:8];
				4'd3:    cur_byte = job_s1.seq[7:0];
				4'd4:    cur_byte = job_s1.ts[31:24];
				4'd5:    cur_byte = job_s1.ts[23:16];
				4'd6:    cur_byte = job_s1.ts[15:8];
				4'd7:    cur_byte = job_s1.ts[7:0];
				4'd8:    cur_byte = job_s1.ssrc[31:24];
				4'd9:    cur_byte = job_s1.ssrc[23:16];
				4'd10:   cur_byte = job_s1.ssrc[15:8];
				4'd11:   cur_byte = job_s1.ssrc[7:0];
				4'd12:   cur_byte = job_s1.fu_ind;
				4'd13:   cur_byte = job_s1.fu_hdr;
				default: cur_byte = job_s1.data;
			endcase
		end
	end

	assign load       = job_valid_s1 && (!out_valid_q || pkt.ready);
	assign take_ready = !job_valid_s1 || (load && at_data);

	// Hold the job and step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (accept) begin
			job_valid_s1 <= job_valid;
			idx_q        <= '0;
		end else if (load) begin
			if (at_data) begin
				job_valid_s1 <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pkt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			out_last_q <= at_data && job_s1.last;
		end
	end

	assign pkt.valid       = out_valid_q;
	assign pkt.packet_byte = out_byte_q;
	assign pkt.packet_last = out_last_q;

endmodule

FILE: rtl/rtp_h264_packetizer_unit.sv
// RTP packetizer for H.264 NAL units with FU-A fragmentation.
// nal_in takes one transaction per NAL byte (kind 0) or per frame tick
// (kind 1); the NAL length and marker request are sampled on a NAL's
// first byte. pkt_out delivers RTP packet bytes, packet_last on the final
// byte of each packet. Registers are written through cfg_write, cfg_index
// and cfg_data: 0 SSRC, 1 payload type, 2 packet size limit, 3 timestamp
// step per tick. The user must do so only while the block is idle; the
// block does not enforce it. Each transaction is decoded combinationally
// into a byte job, held in a job register and shifted out through an
// output register. A NAL body byte yields one packet byte; a byte that
// opens a packet is sent after the RTP header, plus FU indicator and FU
// header for FU-A, one byte per cycle while pkt_out is ready. Ticks and
// the absorbed header byte of a fragmented NAL emit nothing. Reset clears
// sequence number, timestamp and NAL progress, and loads the register
// defaults. When pkt_out stalls, the output register holds, the job
// register fills and nal_in.ready drops until the job drains.
module rtp_h264_packetizer_unit #(
	parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF,
	parameter int LENGTH_BITS      = rhp_pkg::LENGTH_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rhp_nal_if.sink                          nal_in,
	rhp_pkt_if.source                        pkt_out,
	input  logic                             cfg_write,
	input  logic [rhp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rhp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rhp_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic take_ready;
	logic job_valid;
	job_t job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ssrc           <= '0;
			cfg_q.rtp_pt         <= PT_RESET;
			cfg_q.max_packet     <= MTU_RESET;
			cfg_q.timestamp_step <= '0;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SSRC:       cfg_q.ssrc           <= cfg_data;
				CFG_PT:         cfg_q.rtp_pt         <= cfg_data[6:0];
				CFG_MAX_PACKET: cfg_q.max_packet     <= cfg_data[CFG_MTU_W-1:0];
				CFG_TS_STEP:    cfg_q.timestamp_step <= cfg_data;
				default:        cfg_q.ssrc           <= cfg_q.ssrc;
			endcase
		end
	end

	assign nal_in.ready = take_ready;
	assign accept       = nal_in.valid && take_ready;

	rhp_plan #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES),
		.LENGTH_BITS     (LENGTH_BITS)
	) u_plan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.kind      (nal_in.kind),
		.data_byte (nal_in.data_byte),
		.nal_length(nal_in.nal_length),
		.end_marker(nal_in.end_marker),
		.job_valid (job_valid),
		.job       (job)
	);

	rhp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.job_valid (job_valid),
		.job       (job),
		.take_ready(take_ready),
		.pkt       (pkt_out)
	);

endmodule

FILE: rtl/rhp_checker.sv
module rhp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);
	logic [3:0] cnt_q;

	// Count bytes since the last packet end, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (out_valid && out_ready) begin
			if (out_last) begin
				cnt_q <= '0;
			end else if (cnt_q != 4'hf) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// A stalled transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
		else $error("output payload changed while stalled");

	// Input back-pressure only while a job is draining into the output
	a_busy_feeds_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input blocked with nothing moving to the output");

	// Every packet carries at least a header and one payload byte
	a_min_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |-> cnt_q >= 4'd12)
		else $error("packet shorter than header plus one byte");

endmodule

bind rtp_h264_packetizer_unit rhp_checker u_rhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (nal_in.ready),
	.out_valid(pkt_out.valid),
	.out_ready(pkt_out.ready),
	.out_byte (pkt_out.packet_byte),
	.out_last (pkt_out.packet_last)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rhp_pkg::*;

	localparam logic KIND_NAL  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [7:0] FU_START    = 8'h80;
	localparam logic [7:0] FU_END      = 8'h40;
	localparam logic [7:0] F_NRI_MASK  = 8'he0;
	localparam logic [7:0] NO_BITS     = 8'h00;

	localparam int SETTLE_CYCLES = 6;
	localparam int END_CYCLES    = 20;
	localparam int LONG_HOLD     = 300;
	localparam int STUCK_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		logic        kind;
		logic [7:0]  data_byte;
		logic [23:0] nal_length;
		logic        end_marker;
	} nal_item_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} pkt_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rhp_nal_if nal_ch();
	rhp_pkt_if pkt_ch();

	rtp_h264_packetizer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal_in    (nal_ch),
		.pkt_out   (pkt_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies
	logic [31:0] ssrc_reg = '0;
	logic [6:0]  pt_reg   = PT_RESET;
	logic [10:0] mtu_reg  = MTU_RESET;
	logic [31:0] ts_step  = '0;

	// Packetizer state
	logic [15:0] seq_num     = '0;
	logic [31:0] ts_val      = '0;
	logic [23:0] nal_left    = '0;
	logic [10:0] chunk_fill  = '0;
	logic        in_fu       = 1'b0;
	logic [7:0]  fu_ind      = '0;
	logic [4:0]  fu_utype    = '0;
	logic        fu_first    = 1'b0;
	logic        marker_hold = 1'b0;

	nal_item_t pending_items[$];
	pkt_byte_t expected_bytes[$];

	logic nal_took = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned bytes_seen = 0;
	int unsigned stuck_cycles = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned run_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_request = 0;

	function automatic void emit_byte(input logic [7:0] value, input logic last);
		pkt_byte_t e;
		e.value = value;
		e.last = last;
		expected_bytes.push_back(e);
	endfunction

	function automatic void emit_rtp_header(input logic marker);
		emit_byte(RTP_V2_BYTE, 1'b0);
		emit_byte({marker, pt_reg}, 1'b0);
		emit_byte(seq_num[15:8], 1'b0);
		emit_byte(seq_num[7:0], 1'b0);
		emit_byte(ts_val[31:24], 1'b0);
		emit_byte(ts_val[23:16], 1'b0);
		emit_byte(ts_val[15:8], 1'b0);
		emit_byte(ts_val[7:0], 1'b0);
		emit_byte(ssrc_reg[31:24], 1'b0);
		emit_byte(ssrc_reg[23:16], 1'b0);
		emit_byte(ssrc_reg[15:8], 1'b0);
		emit_byte(ssrc_reg[7:0], 1'b0);
		seq_num = seq_num + 16'd1;
	endfunction

	// Work out the packet bytes that one accepted transaction causes
	function automatic void packetize(input nal_item_t it);
		logic [10:0] mtu;
		logic [10:0] chunk_max;
		logic [23:0] n;
		logic frag_end;
		logic close;
		mtu = mtu_reg;
		if (mtu < MIN_PACKET)
			mtu = 11'(MIN_PACKET);
		if (mtu > MAX_PACKET_BYTES_DEF)
			mtu = 11'(MAX_PACKET_BYTES_DEF);
		chunk_max = mtu - 11'(FU_OVERHEAD);
		if (it.kind == KIND_TICK) begin
			ts_val = ts_val + ts_step;
		end else if (nal_left == 0) begin
			// First byte: a zero length counts as one
			n = (it.nal_length == 0) ? 24'd1 : it.nal_length;
			marker_hold = it.end_marker;
			nal_left = n - 24'd1;
			if (32'(n) + HDR_BYTES <= 32'(mtu)) begin
				in_fu = 1'b0;
				emit_rtp_header(marker_hold);
				emit_byte(it.data_byte, nal_left == 0);
			end else begin
				// Absorb the NAL header into the FU indicator and FU header
				in_fu = 1'b1;
				fu_ind = (it.data_byte & F_NRI_MASK) | {3'b000, FU_A_TYPE};
				fu_utype = it.data_byte[4:0];
				fu_first = 1'b1;
				chunk_fill = '0;
			end
		end else if (!in_fu) begin
			nal_left = nal_left - 24'd1;
			emit_byte(it.data_byte, nal_left == 0);
		end else begin
			// End bit and marker follow the limit in force at the fragment's first byte
			if (chunk_fill == 0) begin
				frag_end = nal_left <= 24'(chunk_max);
				emit_rtp_header(marker_hold && frag_end);
				emit_byte(fu_ind, 1'b0);
				emit_byte((fu_first ? FU_START : NO_BITS) | (frag_end ? FU_END : NO_BITS)
					| {3'b000, fu_utype}, 1'b0);
				fu_first = 1'b0;
			end
			nal_left = nal_left - 24'd1;
			chunk_fill = chunk_fill + 11'd1;
			close = (nal_left == 0) || (chunk_fill >= chunk_max);
			if (close)
				chunk_fill = '0;
			emit_byte(it.data_byte, close);
		end
	endfunction

	// Predict on input transactions, check output transactions, watch for a hang
	always @(posedge clk) begin
		pkt_byte_t want;
		logic moved;
		moved = 1'b0;
		nal_took = arst_n && nal_ch.valid && nal_ch.ready;
		if (nal_took) begin
			packetize(pending_items.pop_front());
			moved = 1'b1;
		end
		if (arst_n && pkt_ch.valid && pkt_ch.ready) begin
			moved = 1'b1;
			bytes_seen++;
			if (expected_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("byte %0d: unexpected packet byte %02h last %0b", bytes_seen,
						pkt_ch.packet_byte, pkt_ch.packet_last);
			end else begin
				want = expected_bytes.pop_front();
				if (pkt_ch.packet_byte !== want.value || pkt_ch.packet_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("byte %0d: expected %02h last %0b, got %02h last %0b",
							bytes_seen, want.value, want.last, pkt_ch.packet_byte,
							pkt_ch.packet_last);
				end
			end
		end
		stuck_cycles = moved ? 0 : stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[rtp_h264_packetizer_unit] ERROR");
			$finish;
		end
	end

	// Sender: offer queued transactions in bursts, hold each until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			nal_ch.valid <= 1'b0;
		end else if (nal_ch.valid && !nal_took) begin
			// hold the current offer
		end else if (gap_left != 0) begin
			gap_left--;
			nal_ch.valid <= 1'b0;
		end else if (pending_items.size() != 0) begin
			nal_ch.valid <= 1'b1;
			nal_ch.kind <= pending_items[0].kind;
			nal_ch.data_byte <= pending_items[0].data_byte;
			nal_ch.nal_length <= pending_items[0].nal_length;
			nal_ch.end_marker <= pending_items[0].end_marker;
			if (burst_left > 1) begin
				burst_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				gap_left = 0;
				burst_left = $urandom_range(20, 60);
			end else begin
				gap_left = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 12);
			end
		end else begin
			nal_ch.valid <= 1'b0;
		end
	end

	// Receiver: stall on its own pattern, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			pkt_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			pkt_ch.ready <= 1'b0;
		end else begin
			pkt_ch.ready <= 1'b1;
			if (run_left != 0) begin
				run_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				run_left = $urandom_range(40, 120);
			end else begin
				run_left = $urandom_range(1, 10);
				stall_left = $urandom_range(1, 4);
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_SSRC:       ssrc_reg = value;
			CFG_PT:         pt_reg = value[6:0];
			CFG_MAX_PACKET: mtu_reg = value[10:0];
			CFG_TS_STEP:    ts_step = value;
			default:        ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_item(input logic kind, input logic [7:0] value,
		input logic [23:0] length, input logic marker);
		nal_item_t it;
		it.kind = kind;
		it.data_byte = value;
		it.nal_length = length;
		it.end_marker = marker;
		pending_items.push_back(it);
	endtask

	// Queue NAL bytes; length and marker matter only on an opening byte,
	// so body bytes carry random values there
	task automatic queue_nal(input logic [23:0] length, input int unsigned count,
		input logic marker, input int unsigned tick_odds, input logic opens);
		int unsigned i;
		logic head;
		for (i = 0; i < count; i++) begin
			head = opens && (i == 0);
			if (tick_odds != 0 && !head && $urandom_range(1, tick_odds) == 1)
				queue_item(KIND_TICK, 8'($urandom), 24'($urandom), 1'($urandom));
			queue_item(KIND_NAL, 8'($urandom), head ? length : 24'($urandom),
				head ? marker : 1'($urandom));
		end
	endtask

	task automatic queue_random(input int unsigned items, input int unsigned len_lo,
		input int unsigned len_hi);
		int unsigned pushed;
		int unsigned len;
		pushed = 0;
		while (pushed < items) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_item(KIND_TICK, 8'($urandom), 24'($urandom), 1'($urandom));
				pushed++;
			end else begin
				len = $urandom_range(len_lo, len_hi);
				queue_nal(24'(len), len, 1'($urandom), 12, 1'b1);
				pushed += len;
			end
		end
	endtask

	// Wait until every queued transaction is sent and every expected byte is out, then let the pipe settle
	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		nal_ch.valid = 1'b0;
		nal_ch.kind = KIND_NAL;
		nal_ch.data_byte = '0;
		nal_ch.nal_length = '0;
		nal_ch.end_marker = 1'b0;
		pkt_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: all-ones registers, size limit below the floor
		write_reg(CFG_SSRC, 32'hffff_ffff);
		write_reg(CFG_PT, 32'h0000_007f);
		write_reg(CFG_MAX_PACKET, 32'd0);
		write_reg(CFG_TS_STEP, 32'hffff_ffff);
		queue_item(KIND_TICK, 8'hff, 24'hff_ffff, 1'b1);
		queue_item(KIND_NAL, 8'hff, 24'd0, 1'b1);
		queue_item(KIND_NAL, 8'h00, 24'd1, 1'b0);
		queue_item(KIND_NAL, 8'ha5, 24'd3, 1'b1);
		queue_item(KIND_TICK, 8'h00, 24'd0, 1'b0);
		queue_item(KIND_NAL, 8'h5a, 24'hff_ffff, 1'b0);
		queue_item(KIND_NAL, 8'hc3, 24'h00_0000, 1'b1);
		queue_item(KIND_TICK, 8'h3c, 24'h80_0001, 1'b1);
		wait_idle();

		// Directed: all-zero registers, limit just under the floor
		write_reg(CFG_SSRC, 32'd0);
		write_reg(CFG_PT, 32'd0);
		write_reg(CFG_MAX_PACKET, 32'd63);
		write_reg(CFG_TS_STEP, 32'd0);
		queue_item(KIND_TICK, 8'h81, 24'd5, 1'b0);
		queue_item(KIND_NAL, 8'h7e, 24'd2, 1'b1);
		queue_item(KIND_NAL, 8'h01, 24'd9, 1'b0);
		wait_idle();

		// Smallest limit: fit boundary and fragment boundaries
		write_reg(CFG_SSRC, $urandom);
		write_reg(CFG_PT, $urandom);
		write_reg(CFG_MAX_PACKET, 32'd64);
		write_reg(CFG_TS_STEP, $urandom);
		queue_nal(24'd52, 52, 1'b1, 0, 1'b1);
		queue_nal(24'd53, 53, 1'b1, 0, 1'b1);
		queue_nal(24'd101, 101, 1'b1, 0, 1'b1);
		queue_random(15, 1, 15);
		wait_idle();

		write_reg(CFG_MAX_PACKET, 32'd100);
		write_reg(CFG_PT, $urandom);
		queue_random(20, 1, 25);
		wait_idle();

		// Change the limit and the step in the middle of a fragment
		write_reg(CFG_MAX_PACKET, 32'd64);
		queue_nal(24'd60, 20, 1'b1, 0, 1'b1);
		wait_idle();
		write_reg(CFG_MAX_PACKET, 32'd120);
		write_reg(CFG_TS_STEP, $urandom);
		queue_nal(24'd0, 40, 1'b0, 8, 1'b0);
		wait_idle();

		// Long receiver hold-off while input keeps coming
		write_reg(CFG_MAX_PACKET, 32'd1500);
		write_reg(CFG_SSRC, $urandom);
		write_reg(CFG_PT, $urandom);
		write_reg(CFG_TS_STEP, $urandom);
		@(posedge clk);
		hold_request = LONG_HOLD;
		queue_random(25, 1, 30);
		wait_idle();

		// Limit above the ceiling: a NAL one byte past the fit is fragmented;
		// leave it unfinished
		write_reg(CFG_MAX_PACKET, 32'd2047);
		queue_nal(24'd1489, 25, 1'b1, 10, 1'b1);
		while (pending_items.size() != 0 || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_bytes.size() == 0)
			$display("[rtp_h264_packetizer_unit] OK");
		else
			$display("[rtp_h264_packetizer_unit] ERROR");
		$finish;
	end

endmodule

FILE: rtp_h264_packetizer_unit.f
rtl/rhp_pkg.sv
rtl/rhp_if.sv
rtl/rhp_plan.sv
rtl/rhp_emit.sv
rtl/rtp_h264_packetizer_unit.sv
rtl/rhp_checker.sv
tb/testbench.sv
